// File: hw/rtl/nsc_pkg.sv
// Shared types, constants and helpers for the NMEA sentence checksum checker.
// No dependencies; used by nsc_step and nmea_sentence_checksum_checker.
package nsc_pkg;

    localparam int unsigned CharWidth = 8;

    localparam logic [CharWidth-1:0] START_CHAR = 8'h24;  // '$'
    localparam logic [CharWidth-1:0] DELIM_CHAR = 8'h2A;  // '*'

    typedef enum logic [1:0] {
        PH_WAIT = 2'd0,
        PH_BODY = 2'd1,
        PH_HIGH = 2'd2,
        PH_LOW  = 2'd3
    } t_phase;

    typedef struct packed {
        logic                 checksum_ok;
        logic [CharWidth-1:0] computed_checksum;
        logic [CharWidth-1:0] received_high_char;
        logic [CharWidth-1:0] received_low_char;
    } t_result;

    typedef struct packed {
        t_phase               phase;
        logic [CharWidth-1:0] running_xor;
        logic [CharWidth-1:0] first_digit_char;
    } t_state;

    // Uppercase ASCII hex digit for a nibble.
    function automatic logic [CharWidth-1:0] hex_upper(input logic [3:0] nibble);
        logic [CharWidth-1:0] digit;
        if (nibble < 4'd10) begin
            digit = {4'h3, nibble};
        end else begin
            digit = 8'h37 + {4'h0, nibble};
        end
        return digit;
    endfunction

endpackage

// File: hw/rtl/nsc_step.sv
// Next-state and result logic for one received character.
// Depends on nsc_pkg for the phase enum, state and result structs.
module nsc_step (
    input  nsc_pkg::t_state  i_state,
    input  logic [7:0]       i_byte,
    output nsc_pkg::t_state  o_state,
    output logic             o_result_valid,
    output nsc_pkg::t_result o_result
);
    import nsc_pkg::*;

    always_comb begin
        o_state        = i_state;
        o_result_valid = 1'b0;
        o_result.checksum_ok        = (i_state.first_digit_char ==
                                       hex_upper(i_state.running_xor[7:4])) &&
                                      (i_byte == hex_upper(i_state.running_xor[3:0]));
        o_result.computed_checksum  = i_state.running_xor;
        o_result.received_high_char = i_state.first_digit_char;
        o_result.received_low_char  = i_byte;

        unique case (i_state.phase)
            PH_WAIT: begin
                if (i_byte == START_CHAR) begin
                    o_state.running_xor = '0;
                    o_state.phase       = PH_BODY;
                end
            end
            PH_BODY: begin
                if (i_byte == DELIM_CHAR) begin
                    o_state.phase = PH_HIGH;
                end else begin
                    o_state.running_xor = i_state.running_xor ^ i_byte;
                end
            end
            PH_HIGH: begin
                o_state.first_digit_char = i_byte;
                o_state.phase            = PH_LOW;
            end
            PH_LOW: begin
                o_result_valid = 1'b1;
                o_state.phase  = PH_WAIT;
            end
            default: begin
                o_state.phase = PH_WAIT;
            end
        endcase
    end

endmodule

// File: hw/rtl/nmea_sentence_checksum_checker.sv
// Top level of the NMEA sentence checksum checker: input word register,
// sentence state registers and result register. Depends on nsc_pkg, nsc_step.
//
// Usage:
//   Feed received characters one word per cycle on the s_axis channel. The
//   block waits for '$', XORs every following byte up to the first '*', then
//   takes the next two characters as the transmitted checksum. On the second
//   one it emits one word on m_axis: the computed checksum, both received
//   characters, and an ok flag (tuser) that is set only when the characters
//   are the uppercase two-digit hex of the checksum. All other input words
//   produce no output.
//   Throughput: one input word per cycle while the receiver does not stall,
//   set by the XOR/phase update between input register and state registers.
//   A result reaches m_axis through the input register, then the result
//   register; its last character waits in the input register while full.
//   Reset (i_rst_n low, synchronous) empties both registers and returns the
//   parser to waiting for '$' with a zero checksum.
//   When the receiver stalls, the result is held in the output register;
//   non-result words keep flowing, and a word that would produce a second
//   result waits in the input register, which then deasserts s_axis_tready.
module nmea_sentence_checksum_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] computed_checksum,
                                        // [15:8] received_high_char,
                                        // [23:16] received_low_char
    output logic        m_axis_tuser    // [0] checksum_ok
);
    import nsc_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    t_phase     r_phase, n_phase;
    logic [7:0] r_running_xor, n_running_xor;
    logic [7:0] r_first_digit, n_first_digit;
    logic       r_out_valid;
    t_result    r_result;

    t_state  cur_state;
    t_state  nxt_state;
    logic    step_result_valid;
    t_result step_result;
    logic    out_free;
    logic    advance;

    assign cur_state.phase            = r_phase;
    assign cur_state.running_xor      = r_running_xor;
    assign cur_state.first_digit_char = r_first_digit;

    nsc_step u_step (
        .i_state        (cur_state),
        .i_byte         (r_in_byte),
        .o_state        (nxt_state),
        .o_result_valid (step_result_valid),
        .o_result       (step_result)
    );

    // Advance the held word unless it makes a result and the output is still full.
    assign out_free      = !r_out_valid || m_axis_tready;
    assign advance       = r_in_valid && (!step_result_valid || out_free);
    assign s_axis_tready = !r_in_valid || advance;

    always_comb begin
        n_phase       = r_phase;
        n_running_xor = r_running_xor;
        n_first_digit = r_first_digit;
        if (advance) begin
            n_phase       = nxt_state.phase;
            n_running_xor = nxt_state.running_xor;
            n_first_digit = nxt_state.first_digit_char;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_WAIT;
            r_running_xor <= '0;
        end else begin
            r_phase       <= n_phase;
            r_running_xor <= n_running_xor;
        end
    end

    always_ff @(posedge i_clk) begin
        r_first_digit <= n_first_digit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= advance && step_result_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && advance && step_result_valid) begin
            r_result <= step_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_result.received_low_char,
                            r_result.received_high_char,
                            r_result.computed_checksum};
    assign m_axis_tuser  = r_result.checksum_ok;

endmodule
